// ----- rtl/core/assert_macros.svh -----
// Shared assertion macros for the set store checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked while reset is high.
`define ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication violated");

// Next-cycle implication, masked while reset is high.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication violated");

// Next-cycle implication that is also checked across reset.
`define ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("next-cycle implication violated");

`endif

// ----- rtl/core/bss_pkg.sv -----
package bss_pkg;

   localparam int CAPACITY = 64;
   localparam int OCC_W    = $clog2(CAPACITY + 1);
   localparam int SIZE_W   = 7;
   localparam int VALUE_W  = 32;
   localparam int OP_W     = 2;

   typedef logic [OP_W-1:0] op_type;

   localparam op_type OP_INSERT = 2'd0;
   localparam op_type OP_ERASE  = 2'd1;
   localparam op_type OP_LOOKUP = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   // Search token that travels from cell to cell.
   typedef struct packed {
      logic valid;
      logic found;
   } tok_type;

   // Broadcast from the controller to every cell.
   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic                      insert;
      logic                      erase;
   } cell_ctl_type;

endpackage

// ----- rtl/core/bss_req_if.sv -----
interface bss_req_if import bss_pkg::*; ();
   logic                      valid;
   logic                      ready;
   op_type                    op;
   logic signed [VALUE_W-1:0] value;

   modport source (output valid, output op, output value, input ready);
   modport sink   (input valid, input op, input value, output ready);
endinterface

// ----- rtl/core/bss_rsp_if.sv -----
interface bss_rsp_if import bss_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              found;
   logic              status;
   logic [SIZE_W-1:0] size;

   modport source (output valid, output found, output status, output size, input ready);
   modport sink   (input valid, input found, input status, input size, output ready);
endinterface

// ----- rtl/core/bss_cell.sv -----
module bss_cell import bss_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  cell_ctl_type              ctl,
   input  logic                      live,
   input  logic                      tail_sel,
   input  tok_type                   tok_in,
   input  logic signed [VALUE_W-1:0] next_entry,
   output tok_type                   tok_out,
   output logic signed [VALUE_W-1:0] entry
);

   logic signed [VALUE_W-1:0] entry_ff, entry_in;
   tok_type                   tok_ff, tok_in_next;
   logic                      mark_ff, mark_in;
   logic                      hit;

   // A cell is marked when the hit lies at or before it, so an erase closes
   // the hole by pulling every marked cell one place toward the head.
   assign hit = tok_in.found || (tok_in.valid && live && (entry_ff == ctl.value));

   always_comb begin
      tok_in_next.valid = tok_in.valid;
      tok_in_next.found = hit;
      mark_in           = tok_in.valid ? hit : mark_ff;
      entry_in          = entry_ff;
      if (ctl.insert && tail_sel) begin
         entry_in = ctl.value;
      end else if (ctl.erase && mark_ff) begin
         entry_in = next_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff <= '0;
      end else begin
         tok_ff <= tok_in_next;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      mark_ff  <= mark_in;
   end

   assign tok_out = tok_ff;
   assign entry   = entry_ff;

endmodule

// ----- rtl/core/bss_ctrl.sv -----
module bss_ctrl import bss_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   bss_req_if.sink          req,
   bss_rsp_if.source        rsp,
   input  tok_type          tail_tok,
   output tok_type          head_tok,
   output cell_ctl_type     ctl,
   output logic [OCC_W-1:0] occ
);

   state_type                 state_ff, state_in;
   op_type                    op_ff;
   logic signed [VALUE_W-1:0] value_ff;
   logic                      start_ff;
   logic                      found_ff;
   logic [OCC_W-1:0]          occ_ff, occ_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      rsp_found_ff;
   logic                      rsp_status_ff;
   logic [SIZE_W-1:0]         rsp_size_ff;

   logic accept, commit, out_free, full, refused, do_insert, do_erase;

   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign accept    = req.valid && req.ready;
   assign full      = (occ_ff >= OCC_W'(CAPACITY));
   assign refused   = (op_ff == OP_INSERT) && !found_ff && full;
   assign do_insert = commit && (op_ff == OP_INSERT) && !found_ff && !full;
   assign do_erase  = commit && (op_ff == OP_ERASE) && found_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (req.valid) state_in = ST_SCAN;
         ST_SCAN:   if (tail_tok.valid) state_in = ST_FINISH;
         ST_FINISH: if (out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req.ready = 1'b0;
      commit    = 1'b0;
      case (state_ff)
         ST_IDLE:   req.ready = 1'b1;
         ST_SCAN:   ;
         ST_FINISH: commit = out_free;
         default:   ;
      endcase
   end

   always_comb begin
      occ_in = occ_ff;
      if (do_insert) begin
         occ_in = occ_ff + OCC_W'(1);
      end else if (do_erase) begin
         occ_in = occ_ff - OCC_W'(1);
      end
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      if (commit) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         start_ff     <= 1'b0;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         start_ff     <= accept;
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff    <= req.op;
         value_ff <= req.value;
      end
      if (tail_tok.valid) begin
         found_ff <= tail_tok.found;
      end
      if (commit) begin
         rsp_found_ff  <= found_ff;
         rsp_status_ff <= refused;
         rsp_size_ff   <= SIZE_W'(occ_in);
      end
   end

   assign head_tok.valid = start_ff;
   assign head_tok.found = 1'b0;
   assign ctl.value      = value_ff;
   assign ctl.insert     = do_insert;
   assign ctl.erase      = do_erase;
   assign occ            = occ_ff;

   assign rsp.valid  = rsp_valid_ff;
   assign rsp.found  = rsp_found_ff;
   assign rsp.status = rsp_status_ff;
   assign rsp.size   = rsp_size_ff;

endmodule

// ----- rtl/core/bounded_set_store.sv -----
// Bounded set store: a set of distinct 32-bit values held in a row of
// CAPACITY cells, one stored value per cell, plus an occupancy count.
// The req channel carries one transaction per request (op and value: insert,
// erase or lookup); the rsp channel returns one transaction per request with
// found, status (insert refused because full) and the size after the request.
// A request is accepted only while no other is in progress. A search token
// then walks the chain one cell per cycle; once it leaves the last cell,
// the request commits as soon as the output register is free. An erase
// closes its hole by moving every cell past the hit one place toward
// the head at once.
// The response sits in an output register: a new request is accepted and
// searched while an earlier response still waits, and only its final commit
// waits for the receiver to take that response.
// Reset empties the set at once (the count goes to zero; cell contents are
// left as they are and never read until written again).
module bounded_set_store import bss_pkg::*; (
   input logic       clock,
   input logic       reset,
   bss_req_if.sink   req,
   bss_rsp_if.source rsp
);

   tok_type                   tok [CAPACITY+1];
   logic signed [VALUE_W-1:0] entry [CAPACITY];
   cell_ctl_type              ctl;
   logic [OCC_W-1:0]          occ;

   bss_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req      (req),
      .rsp      (rsp),
      .tail_tok (tok[CAPACITY]),
      .head_tok (tok[0]),
      .ctl      (ctl),
      .occ      (occ)
   );

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [VALUE_W-1:0] next_entry;
      logic                      live;
      logic                      tail_sel;

      if (i == CAPACITY - 1) begin : g_last
         assign next_entry = entry[i];
      end else begin : g_mid
         assign next_entry = entry[i+1];
      end

      assign live     = (OCC_W'(i) < occ);
      assign tail_sel = (OCC_W'(i) == occ);

      bss_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .live       (live),
         .tail_sel   (tail_sel),
         .tok_in     (tok[i]),
         .next_entry (next_entry),
         .tok_out    (tok[i+1]),
         .entry      (entry[i])
      );
   end

endmodule

// ----- rtl/core/bss_checker.sv -----
`include "assert_macros.svh"

module bss_checker import bss_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic              rsp_found,
   input logic              rsp_status,
   input logic [SIZE_W-1:0] rsp_size
);

   // A response waiting for the receiver stays offered.
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)

   // A refused insert only happens with the store full.
   `ASSERT_IMP(a_refuse_full, clock, reset, rsp_valid && rsp_status,
      rsp_size == SIZE_W'(CAPACITY))

   // A refused insert means the value was absent.
   `ASSERT_IMP(a_refuse_absent, clock, reset, rsp_valid && rsp_status, !rsp_found)

   // Reset drops any pending response.
   `ASSERT_NEXT_ALWAYS(a_reset_clear, clock, reset, !rsp_valid)

endmodule

bind bounded_set_store bss_checker u_bss_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp.valid),
   .rsp_ready  (rsp.ready),
   .rsp_found  (rsp.found),
   .rsp_status (rsp.status),
   .rsp_size   (rsp.size)
);
